/* src/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants, register codes and helpers for the stereo mixer core.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int MAX_CH   = 4;
  localparam int Q_SHIFT  = 14;
  localparam int OUT_W    = 19;
  localparam int CFG_W    = 64;
  localparam int FIELD_W  = 16;

  localparam logic [15:0] GAIN_MAX   = 16'd19661;
  localparam logic [15:0] PAN_CENTER = 16'd8192;
  localparam logic [15:0] PAN_FULL   = 16'd16384;
  localparam logic [14:0] Q_ONE      = 15'd16384;

  localparam logic [63:0] GAINS_RST  = 64'h4000_4000_4000_4000;
  localparam logic [63:0] PANS_RST   = 64'h2000_2000_2000_2000;
  localparam logic [14:0] MGAIN_RST  = 15'd16384;

  typedef enum logic [1:0] {
    REG_CH_GAINS = 2'd0,
    REG_CH_PANS  = 2'd1,
    REG_MGAIN_L  = 2'd2,
    REG_MGAIN_R  = 2'd3
  } cfg_reg_t;

  // master section controls handed to the merge stage
  typedef struct packed {
    logic [14:0] gain_l;
    logic [14:0] gain_r;
    logic [1:0]  mute;
  } master_ctl_t;

  function automatic logic [14:0] clamp_gain(input logic [15:0] g);
    logic [14:0] res;
    res = (g > GAIN_MAX) ? GAIN_MAX[14:0] : g[14:0];
    return res;
  endfunction

endpackage

/* src/smx_intf.sv */
// ----------------------------------------------------------------------------
// smx_in_if / smx_out_if
// Valid/ready channels carrying one mixer frame in and one mixed result out.
// ----------------------------------------------------------------------------
interface smx_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_ch0;
  logic signed [SAMPLE_BITS-1:0] sample_ch1;
  logic signed [SAMPLE_BITS-1:0] sample_ch2;
  logic signed [SAMPLE_BITS-1:0] sample_ch3;
  logic [3:0]                    connected_mask;
  logic [3:0]                    mute_button_levels;
  logic [3:0]                    solo_button_levels;
  logic [1:0]                    master_button_levels;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           connected_mask, mute_button_levels, solo_button_levels,
           master_button_levels,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           connected_mask, mute_button_levels, solo_button_levels,
           master_button_levels,
    output ready
  );
endinterface

interface smx_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] main_left;
  logic signed [18:0] main_right;
  logic [3:0]         mute_lights;
  logic [3:0]         solo_lights;
  logic [1:0]         master_mute_lights;

  modport source (
    output valid, main_left, main_right, mute_lights, solo_lights,
           master_mute_lights,
    input  ready
  );
  modport sink (
    input  valid, main_left, main_right, mute_lights, solo_lights,
           master_mute_lights,
    output ready
  );
endinterface

/* src/smx_lane.sv */
// ----------------------------------------------------------------------------
// smx_lane
// One channel strip: gain multiply, then linear pan split to left and right.
// ----------------------------------------------------------------------------
module smx_lane #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          en,
  input  logic [15:0]                   gain,
  input  logic [15:0]                   pan,
  output logic signed [SAMPLE_BITS+1:0] left,
  output logic signed [SAMPLE_BITS+1:0] right
);

  localparam int XW  = SAMPLE_BITS + 2;
  localparam int P1W = SAMPLE_BITS + 16;
  localparam int P2W = XW + 16;

  logic [14:0]           gain_c;
  logic signed [P1W-1:0] prod_g;
  logic signed [XW-1:0]  x_r;
  logic [15:0]           pan_c;
  logic [15:0]           pan_rem;
  logic [14:0]           fac_l;
  logic [14:0]           fac_r;
  logic signed [P2W-1:0] prod_l;
  logic signed [P2W-1:0] prod_r;

  assign gain_c = smx_pkg::clamp_gain(gain);
  assign prod_g = sample * $signed({1'b0, gain_c});

  // a disabled channel contributes zero
  always_ff @(posedge clk) begin
    x_r <= en ? XW'(prod_g >>> smx_pkg::Q_SHIFT) : '0;
  end

  // pan factors; the side toward which the pan leans stays at unity
  always_comb begin
    pan_c   = (pan > smx_pkg::PAN_FULL) ? smx_pkg::PAN_FULL : pan;
    pan_rem = smx_pkg::PAN_FULL - pan_c;
    fac_l   = (pan_c > smx_pkg::PAN_CENTER) ? {pan_rem[13:0], 1'b0} : smx_pkg::Q_ONE;
    fac_r   = (pan_c < smx_pkg::PAN_CENTER) ? {pan_c[13:0], 1'b0} : smx_pkg::Q_ONE;
  end

  assign prod_l = x_r * $signed({1'b0, fac_l});
  assign prod_r = x_r * $signed({1'b0, fac_r});

  // factors never exceed unity, so the shifted products fit the lane width
  always_ff @(posedge clk) begin
    left  <= XW'(prod_l >>> smx_pkg::Q_SHIFT);
    right <= XW'(prod_r >>> smx_pkg::Q_SHIFT);
  end

endmodule

/* src/smx_merge.sv */
// ----------------------------------------------------------------------------
// smx_merge
// Sum the lanes per side, then apply master gain or master mute.
// ----------------------------------------------------------------------------
module smx_merge #(
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS+1:0] lane_l [CHANNELS],
  input  logic signed [SAMPLE_BITS+1:0] lane_r [CHANNELS],
  input  smx_pkg::master_ctl_t          mctl,
  output logic signed [18:0]            main_left,
  output logic signed [18:0]            main_right
);

  localparam int SW = SAMPLE_BITS + 4;
  localparam int MW = SW + 16;

  logic signed [SW-1:0] sum_l;
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] sum_l_r;
  logic signed [SW-1:0] sum_r_r;
  logic [14:0]          gl_c;
  logic [14:0]          gr_c;
  logic signed [MW-1:0] prod_l;
  logic signed [MW-1:0] prod_r;

  always_comb begin
    sum_l = '0;
    sum_r = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      sum_l = sum_l + SW'(lane_l[i]);
      sum_r = sum_r + SW'(lane_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    sum_l_r <= sum_l;
    sum_r_r <= sum_r;
  end

  assign gl_c   = smx_pkg::clamp_gain({1'b0, mctl.gain_l});
  assign gr_c   = smx_pkg::clamp_gain({1'b0, mctl.gain_r});
  assign prod_l = sum_l_r * $signed({1'b0, gl_c});
  assign prod_r = sum_r_r * $signed({1'b0, gr_c});

  // output register: hold until the next frame reaches this stage
  always_ff @(posedge clk) begin
    if (load) begin
      main_left  <= mctl.mute[0] ? '0 : smx_pkg::OUT_W'(prod_l >>> smx_pkg::Q_SHIFT);
      main_right <= mctl.mute[1] ? '0 : smx_pkg::OUT_W'(prod_r >>> smx_pkg::Q_SHIFT);
    end
  end

endmodule

/* src/stereo_mixer_mute_solo_pan_core.sv */
// ----------------------------------------------------------------------------
// stereo_mixer_mute_solo_pan_core
// Stereo mixer with per-channel gain, linear pan, mute and solo toggles,
// and per-side master gain and master mute.
// ----------------------------------------------------------------------------
// One frame is in flight at a time. A frame is taken, its button edges update
// the mute, solo and master flags, and it then runs through a fixed pipeline
// of four register stages (gain multiply, pan multiply, lane sum, master
// multiply) before the result beat is shown. The next input beat is taken in
// the cycle after the result beat is accepted, so a new frame is not taken
// until the result of the last one has been accepted.
// Configuration writes land at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module stereo_mixer_mute_solo_pan_core #(
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  smx_in_if.sink                          in_ch,
  smx_out_if.source                       out_ch,
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [smx_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam logic [3:0] CH_MASK = 4'((1 << CHANNELS) - 1);

  // configuration registers
  logic [63:0] gains_r;
  logic [63:0] pans_r;
  logic [14:0] mgain_l_r;
  logic [14:0] mgain_r_r;

  // button and flag state
  logic [3:0] pmute_r, psolo_r, mute_r, solo_r;
  logic [1:0] pmaster_r, mmute_r;
  logic [3:0] mb, sb, mute_nxt, solo_nxt, en_nxt;
  logic [1:0] gb, mmute_nxt;

  // frame registers and control
  logic signed [SAMPLE_BITS-1:0] smp    [smx_pkg::MAX_CH];
  logic signed [SAMPLE_BITS-1:0] smp_r  [CHANNELS];
  logic [CHANNELS-1:0]           en_r;
  logic                          busy_r;
  logic [3:0]                    vld_r;
  logic                          out_vld_r;
  logic                          in_acc;
  logic                          out_acc;

  logic signed [SAMPLE_BITS+1:0] lane_l [CHANNELS];
  logic signed [SAMPLE_BITS+1:0] lane_r [CHANNELS];
  smx_pkg::master_ctl_t          mctl;

  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && !busy_r;
  assign out_acc     = out_vld_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r   <= smx_pkg::GAINS_RST;
      pans_r    <= smx_pkg::PANS_RST;
      mgain_l_r <= smx_pkg::MGAIN_RST;
      mgain_r_r <= smx_pkg::MGAIN_RST;
    end else if (cfg_wr_en) begin
      unique case (smx_pkg::cfg_reg_t'(cfg_index))
        smx_pkg::REG_CH_GAINS: gains_r   <= cfg_wdata;
        smx_pkg::REG_CH_PANS:  pans_r    <= cfg_wdata;
        smx_pkg::REG_MGAIN_L:  mgain_l_r <= cfg_wdata[14:0];
        smx_pkg::REG_MGAIN_R:  mgain_r_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // toggle on rising button edges, before the mix is formed
  always_comb begin
    mb        = in_ch.mute_button_levels & CH_MASK;
    sb        = in_ch.solo_button_levels & CH_MASK;
    gb        = in_ch.master_button_levels;
    mute_nxt  = (mute_r ^ (mb & ~pmute_r)) & CH_MASK;
    solo_nxt  = (solo_r ^ (sb & ~psolo_r)) & CH_MASK;
    mmute_nxt = mmute_r ^ (gb & ~pmaster_r);
    en_nxt    = in_ch.connected_mask & ~mute_nxt & ((|solo_nxt) ? solo_nxt : 4'hF);
  end

  assign smp[0] = in_ch.sample_ch0;
  assign smp[1] = in_ch.sample_ch1;
  assign smp[2] = in_ch.sample_ch2;
  assign smp[3] = in_ch.sample_ch3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmute_r   <= '0;
      psolo_r   <= '0;
      mute_r    <= '0;
      solo_r    <= '0;
      pmaster_r <= '0;
      mmute_r   <= '0;
    end else if (in_acc) begin
      pmute_r   <= mb;
      psolo_r   <= sb;
      mute_r    <= mute_nxt;
      solo_r    <= solo_nxt;
      pmaster_r <= gb;
      mmute_r   <= mmute_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < CHANNELS; i++) begin
        smp_r[i] <= smp[i];
      end
      en_r <= en_nxt[CHANNELS-1:0];
    end
  end

  // one frame at a time: advance a valid token through the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r <= {vld_r[2:0], in_acc};
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (out_acc) begin
        busy_r <= 1'b0;
      end
      if (vld_r[3]) begin
        out_vld_r <= 1'b1;
      end else if (out_acc) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    smx_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk    (clk),
      .sample (smp_r[g]),
      .en     (en_r[g]),
      .gain   (gains_r[smx_pkg::FIELD_W*g +: smx_pkg::FIELD_W]),
      .pan    (pans_r[smx_pkg::FIELD_W*g +: smx_pkg::FIELD_W]),
      .left   (lane_l[g]),
      .right  (lane_r[g])
    );
  end

  assign mctl.gain_l = mgain_l_r;
  assign mctl.gain_r = mgain_r_r;
  assign mctl.mute   = mmute_r;

  smx_merge #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk        (clk),
    .load       (vld_r[3]),
    .lane_l     (lane_l),
    .lane_r     (lane_r),
    .mctl       (mctl),
    .main_left  (out_ch.main_left),
    .main_right (out_ch.main_right)
  );

  assign out_ch.valid              = out_vld_r;
  assign out_ch.mute_lights        = mute_r;
  assign out_ch.solo_lights        = solo_r;
  assign out_ch.master_mute_lights = mmute_r;

`ifndef SYNTHESIS
  a_out_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> busy_r)
    else $error("result beat shown with no frame in flight");

  a_accept_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (vld_r == '0) && !out_vld_r)
    else $error("input beat taken while a frame is still in flight");

  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({vld_r, out_vld_r}))
    else $error("more than one frame in the pipeline");

  a_master_mute_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && mmute_r[0]) |-> (out_ch.main_left == '0))
    else $error("left output nonzero while left master is muted");
`endif

endmodule

/* dv/smx_mix_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smx_mix_checker
// Watches the frame and result channels of the stereo mixer and the register
// write port. Keeps its own copy of the button, flag and gain state, works
// out the mixed result of every accepted frame, and compares each result
// beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module smx_mix_checker
  import smx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  smx_in_if           in_mon,
  smx_out_if          out_mon,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          outstanding,
  output int          fail_count
);

  typedef struct packed {
    logic [18:0] left;
    logic [18:0] right;
    logic [3:0]  mute;
    logic [3:0]  solo;
    logic [1:0]  mst;
  } mix_result_t;

  mix_result_t expected_mixes[$];

  logic [63:0] gains_q;
  logic [63:0] pans_q;
  logic [14:0] mgain_l;
  logic [14:0] mgain_r;
  logic [3:0]  mute_prev;
  logic [3:0]  solo_prev;
  logic [3:0]  mute_flags;
  logic [3:0]  solo_flags;
  logic [1:0]  mst_prev;
  logic [1:0]  mst_flags;

  function automatic longint gain_lane(input logic [15:0] g);
    if (g > GAIN_MAX) return longint'(GAIN_MAX);
    return longint'(g);
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  task automatic predict_mix();
    logic [3:0][15:0] smp;
    logic [3:0]       conn;
    logic [3:0]       mb;
    logic [3:0]       sb;
    logic [1:0]       gb;
    longint           sample;
    longint           gain;
    longint           pan;
    longint           lane_l;
    longint           lane_r;
    longint           sum_l;
    longint           sum_r;
    mix_result_t      res;
    smp  = {in_mon.sample_ch3, in_mon.sample_ch2, in_mon.sample_ch1, in_mon.sample_ch0};
    conn = in_mon.connected_mask;
    mb   = in_mon.mute_button_levels;
    sb   = in_mon.solo_button_levels;
    gb   = in_mon.master_button_levels;
    // toggles land before this frame is mixed
    mute_flags = mute_flags ^ (mb & ~mute_prev);
    solo_flags = solo_flags ^ (sb & ~solo_prev);
    mute_prev  = mb;
    solo_prev  = sb;
    sum_l = 0;
    sum_r = 0;
    for (int c = 0; c < MAX_CH; c++) begin
      if (conn[c] && !mute_flags[c] && (solo_flags == 4'd0 || solo_flags[c])) begin
        sample = longint'($signed(smp[c]));
        gain   = gain_lane(gains_q[16*c +: 16]);
        pan    = longint'(pans_q[16*c +: 16]);
        if (pan > longint'(PAN_FULL)) pan = longint'(PAN_FULL);
        lane_l = (sample * gain) >>> Q_SHIFT;
        lane_r = lane_l;
        // linear pan: only the far side is attenuated
        if (pan < longint'(PAN_CENTER)) begin
          lane_r = (lane_r * (2 * pan)) >>> Q_SHIFT;
        end else if (pan > longint'(PAN_CENTER)) begin
          lane_l = (lane_l * (2 * (longint'(PAN_FULL) - pan))) >>> Q_SHIFT;
        end
        sum_l += lane_l;
        sum_r += lane_r;
      end
    end
    mst_flags = mst_flags ^ (gb & ~mst_prev);
    mst_prev  = gb;
    if (mst_flags[0]) sum_l = 0;
    else sum_l = (sum_l * gain_lane({1'b0, mgain_l})) >>> Q_SHIFT;
    if (mst_flags[1]) sum_r = 0;
    else sum_r = (sum_r * gain_lane({1'b0, mgain_r})) >>> Q_SHIFT;
    res.left  = sum_l[18:0];
    res.right = sum_r[18:0];
    res.mute  = mute_flags;
    res.solo  = solo_flags;
    res.mst   = mst_flags;
    expected_mixes.push_back(res);
  endtask

  task automatic check_result();
    mix_result_t want;
    if (expected_mixes.size() == 0) begin
      report_mismatch("result beat with no frame outstanding");
      return;
    end
    want = expected_mixes.pop_front();
    if (out_mon.main_left !== want.left)
      report_mismatch($sformatf("main_left got %0d expected %0d",
                                $signed(out_mon.main_left), $signed(want.left)));
    if (out_mon.main_right !== want.right)
      report_mismatch($sformatf("main_right got %0d expected %0d",
                                $signed(out_mon.main_right), $signed(want.right)));
    if (out_mon.mute_lights !== want.mute)
      report_mismatch($sformatf("mute_lights got %b expected %b",
                                out_mon.mute_lights, want.mute));
    if (out_mon.solo_lights !== want.solo)
      report_mismatch($sformatf("solo_lights got %b expected %b",
                                out_mon.solo_lights, want.solo));
    if (out_mon.master_mute_lights !== want.mst)
      report_mismatch($sformatf("master_mute_lights got %b expected %b",
                                out_mon.master_mute_lights, want.mst));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gains_q    = GAINS_RST;
      pans_q     = PANS_RST;
      mgain_l    = MGAIN_RST;
      mgain_r    = MGAIN_RST;
      mute_prev  = '0;
      solo_prev  = '0;
      mute_flags = '0;
      solo_flags = '0;
      mst_prev   = '0;
      mst_flags  = '0;
      fail_count = 0;
      expected_mixes.delete();
    end else begin
      // a result beat always belongs to an earlier frame
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready) predict_mix();
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_CH_GAINS: gains_q = cfg_wdata;
          REG_CH_PANS:  pans_q  = cfg_wdata;
          REG_MGAIN_L:  mgain_l = cfg_wdata[14:0];
          REG_MGAIN_R:  mgain_r = cfg_wdata[14:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_mixes.size();
  end

endmodule

/* dv/tb_stereo_mixer_mute_solo_pan_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_mixer_mute_solo_pan_core
// Drives mixer frames and register settings into the core, with random
// sender gaps and receiver stalls, a long output hold-off and full drains.
// A directed set covers sample extremes, mute, solo and master toggles;
// random frames follow under several gain and pan settings.
// ----------------------------------------------------------------------------
module tb_stereo_mixer_mute_solo_pan_core;
  import smx_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 228;
  localparam int HOLD_AT        = 75;
  localparam int DRAIN_AT       = 150;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]       mst;
    logic [3:0]       solo;
    logic [3:0]       mute;
    logic [3:0]       conn;
    logic [3:0][15:0] smp;
  } mix_frame_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int          outstanding;
  int          fail_count;
  int          stall_cycles;

  int          tx_idle_pct    = 0;
  int          rx_stall_pct   = 0;
  int          rx_holds_asked = 0;

  // button levels last sent and the flag state they imply
  logic [3:0]  mute_lvl_q = '0;
  logic [3:0]  solo_lvl_q = '0;
  logic [1:0]  mst_lvl_q  = '0;
  logic [3:0]  mute_on    = '0;
  logic [3:0]  solo_on    = '0;
  logic [1:0]  mst_on     = '0;

  smx_in_if #(.SAMPLE_BITS(16)) in_ch ();
  smx_out_if                    out_ch ();

  stereo_mixer_mute_solo_pan_core #(
    .CHANNELS    (4),
    .SAMPLE_BITS (16)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  smx_mix_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  wire in_beat  = in_ch.valid && in_ch.ready;
  wire out_beat = out_ch.valid && out_ch.ready;

  always @(posedge clk) begin
    if (!rst_n || in_beat || out_beat) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("stereo_mixer_mute_solo_pan_core: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int holds_done;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != rx_holds_asked) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        for (int n = 0; n < RX_HOLD_CYCLES; n++) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic push_frame(input mix_frame_t f);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid                <= 1'b1;
    in_ch.sample_ch0           <= f.smp[0];
    in_ch.sample_ch1           <= f.smp[1];
    in_ch.sample_ch2           <= f.smp[2];
    in_ch.sample_ch3           <= f.smp[3];
    in_ch.connected_mask       <= f.conn;
    in_ch.mute_button_levels   <= f.mute;
    in_ch.solo_button_levels   <= f.solo;
    in_ch.master_button_levels <= f.mst;
    do @(posedge clk); while (!in_ch.ready);
    mute_on    = mute_on ^ (f.mute & ~mute_lvl_q);
    solo_on    = solo_on ^ (f.solo & ~solo_lvl_q);
    mst_on     = mst_on ^ (f.mst & ~mst_lvl_q);
    mute_lvl_q = f.mute;
    solo_lvl_q = f.solo;
    mst_lvl_q  = f.mst;
  endtask

  task automatic send_directed(input logic [15:0] s0, s1, s2, s3,
                               input logic [3:0] conn, mute, solo,
                               input logic [1:0] mst);
    mix_frame_t f;
    f.smp  = {s3, s2, s1, s0};
    f.conn = conn;
    f.mute = mute;
    f.solo = solo;
    f.mst  = mst;
    push_frame(f);
  endtask

  // hold off the sender until every result is back and the core is quiet
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [63:0] gains, pans,
                               input logic [14:0] gain_l, gain_r);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CH_GAINS;
    cfg_wdata <= gains;
    @(posedge clk);
    cfg_index <= REG_CH_PANS;
    cfg_wdata <= pans;
    @(posedge clk);
    cfg_index <= REG_MGAIN_L;
    cfg_wdata <= 64'(gain_l);
    @(posedge clk);
    cfg_index <= REG_MGAIN_R;
    cfg_wdata <= 64'(gain_r);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly momentary presses; set flags are cleared again fairly soon
  function automatic logic [3:0] next_levels(input logic [3:0] prev, on,
                                             input int set_pct, clr_pct, width);
    logic [3:0] lvl;
    lvl = ($urandom_range(99) < 30) ? prev : 4'd0;
    if ($urandom_range(99) < set_pct) lvl[$urandom_range(width - 1)] = 1'b1;
    if (on != 4'd0 && $urandom_range(99) < clr_pct) lvl = lvl | on;
    return lvl;
  endfunction

  task automatic next_random_frame(output mix_frame_t f);
    logic [3:0] lvl;
    if ($urandom_range(99) < 4) begin
      f.mute = 4'($urandom);
      f.solo = 4'($urandom);
      f.mst  = 2'($urandom);
    end else begin
      f.mute = next_levels(mute_lvl_q, mute_on, 10, 20, 4);
      f.solo = next_levels(solo_lvl_q, solo_on, 4, 25, 4);
      lvl    = next_levels({2'b00, mst_lvl_q}, {2'b00, mst_on}, 4, 25, 2);
      f.mst  = lvl[1:0];
    end
    f.conn = ($urandom_range(99) < 75) ? 4'hF : 4'($urandom);
    for (int c = 0; c < MAX_CH; c++) begin
      case ($urandom_range(7))
        0:       f.smp[c] = 16'h7FFF;
        1:       f.smp[c] = 16'h8000;
        2:       f.smp[c] = 16'h0000;
        3:       f.smp[c] = 16'hFFFF;
        4:       f.smp[c] = 16'($urandom_range(0, 255));
        default: f.smp[c] = 16'($urandom);
      endcase
    end
  endtask

  initial begin
    mix_frame_t  f;
    logic [63:0] gains;
    logic [63:0] pans;
    logic [14:0] gain_l;
    logic [14:0] gain_r;

    rst_n                      <= 1'b0;
    cfg_wr_en                  <= 1'b0;
    cfg_index                  <= REG_CH_GAINS;
    cfg_wdata                  <= '0;
    in_ch.valid                <= 1'b0;
    in_ch.sample_ch0           <= '0;
    in_ch.sample_ch1           <= '0;
    in_ch.sample_ch2           <= '0;
    in_ch.sample_ch3           <= '0;
    in_ch.connected_mask       <= '0;
    in_ch.mute_button_levels   <= '0;
    in_ch.solo_button_levels   <= '0;
    in_ch.master_button_levels <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames under reset settings
    send_directed(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'hF, 4'h0, 4'h0, 2'b00);
    send_directed(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'hF, 4'h0, 4'h0, 2'b00);
    send_directed(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'hF, 4'h0, 4'h0, 2'b00);
    send_directed(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 4'h0, 4'h0, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h1, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h1, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h0, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h1, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'hF, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h0, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'hF, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h0, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h0, 4'h2, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h0, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h0, 4'h4, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h0, 4'h6, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h0, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h0, 4'h4, 2'b00);
    // a channel both muted and soloed stays silent and silences the rest
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h8, 4'h8, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h0, 4'h0, 2'b00);
    send_directed(16'd1000, 16'hF830, 16'd3000, 16'h8000, 4'hF, 4'h8, 4'h8, 2'b00);
    send_directed(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 4'hA, 4'h0, 4'h0, 2'b01);
    send_directed(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'hF, 4'h0, 4'h0, 2'b11);
    send_directed(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'hF, 4'h0, 4'h0, 2'b00);
    send_directed(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'hF, 4'h0, 4'h0, 2'b11);
    send_directed(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'hF, 4'h0, 4'h0, 2'b00);

    for (int ph = 1; ph <= PHASES; ph++) begin
      wait_drained();
      case (ph)
        1: begin
          gains  = {4{16'hFFFF}};
          pans   = {16'hFFFF, PAN_FULL, 16'd1, 16'd0};
          gain_l = 15'h7FFF;
          gain_r = GAIN_MAX[14:0];
        end
        2: begin
          gains  = '0;
          pans   = '0;
          gain_l = '0;
          gain_r = '0;
        end
        default: begin
          for (int c = 0; c < MAX_CH; c++) begin
            case ($urandom_range(5))
              0:       gains[16*c +: 16] = 16'hFFFF;
              1:       gains[16*c +: 16] = GAIN_MAX + 16'd1;
              2:       gains[16*c +: 16] = GAIN_MAX;
              3:       gains[16*c +: 16] = {1'b0, Q_ONE};
              default: gains[16*c +: 16] = 16'($urandom_range(0, 19661));
            endcase
            case ($urandom_range(6))
              0:       pans[16*c +: 16] = 16'd0;
              1:       pans[16*c +: 16] = PAN_CENTER;
              2:       pans[16*c +: 16] = PAN_FULL;
              3:       pans[16*c +: 16] = 16'($urandom_range(16385, 65535));
              4:       pans[16*c +: 16] = PAN_CENTER - 16'd1;
              default: pans[16*c +: 16] = 16'($urandom_range(0, 16384));
            endcase
          end
          gain_l = ($urandom_range(3) == 0) ? 15'h7FFF : 15'($urandom_range(0, 19661));
          gain_r = ($urandom_range(3) == 0) ? 15'h7FFF : 15'($urandom_range(0, 19661));
        end
      endcase
      load_settings(gains, pans, gain_l, gain_r);

      case ((ph - 1) % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 80; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 80; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back up the core behind a stalled receiver, then empty it later
        if (n == HOLD_AT) rx_holds_asked++;
        if (n == DRAIN_AT) wait_drained();
        next_random_frame(f);
        push_frame(f);
      end
    end

    wait_drained();
    if (fail_count == 0 && outstanding == 0) begin
      $display("stereo_mixer_mute_solo_pan_core: match");
    end else begin
      $display("stereo_mixer_mute_solo_pan_core: mismatch");
    end
    $finish;
  end

endmodule
